[rtl/core/bba_pkg.sv]
// bba_pkg: shared types, codes and helpers for the bitmap block allocator
// no dependencies; imported by bba_div and bitmap_block_allocator
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    localparam int KIND_W  = 2;
    localparam int IDX_W   = 16;
    localparam int CNT_W   = 17;
    localparam int STAT_W  = 2;
    localparam int DIV_N   = 17;
    localparam int WORD_MAX = 64;
    localparam int FZ_W    = 7;

    // request kinds
    localparam logic [KIND_W-1:0] K_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] K_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] K_TEST   = 2'd2;
    localparam logic [KIND_W-1:0] K_FORMAT = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // register indexes
    localparam logic REG_TOTAL = 1'b0;
    localparam logic REG_RSV   = 1'b1;

    localparam logic [CNT_W-1:0] TOTAL_RST = 17'd65536;
    localparam logic [CNT_W-1:0] CNT_MAX   = 17'h1ffff;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  block_index;
    } bba_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  block_number;
        logic              bit_value;
        logic [CNT_W-1:0]  free_count;
    } bba_rsp_t;

    // lowest clear bit; WORD_MAX when every bit is set
    function automatic logic [FZ_W-1:0] first_zero(input logic [WORD_MAX-1:0] word);
        logic [FZ_W-1:0] pos;
        pos = FZ_W'(WORD_MAX);
        for (int i = WORD_MAX - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                pos = FZ_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

[rtl/core/bba_ram.sv]
// bba_ram: single write port, single read port memory with registered read data
// depends on nothing; used for the usage map and the full-word summary
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    parameter int AW    = 10
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/bba_div.sv]
// bba_div: two-stage divide by the word size using a reciprocal multiply
// depends on bba_pkg; splits a bit number into word and bit, or a word into summary word and bit
`timescale 1ns / 1ps
`default_nettype none

module bba_div
    import bba_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           go,
    input  wire logic [DIV_N-1:0]               value,
    output logic                                vld,
    output logic [DIV_N-1:0]                    quo,
    output logic [$clog2(WORD_BITS)-1:0]        rem
);

    localparam int WB_W     = $clog2(WORD_BITS);
    localparam int RECIP_SH = DIV_N + WB_W;
    localparam int RECIP_M  = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W   = DIV_N + RECIP_SH;

    logic              vld1_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DIV_N-1:0]  val1_reg;
    logic [DIV_N-1:0]  q_next;
    logic [DIV_N-1:0]  qw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld      <= 1'b0;
        end
        else
        begin
            vld1_reg <= go;
            vld      <= vld1_reg;
        end
    end

    // rounded-up reciprocal is exact for every DIV_N-bit value
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(value) * PROD_W'(RECIP_M);
        val1_reg <= value;
        quo      <= q_next;
        rem      <= WB_W'(val1_reg - qw);
    end

    always_comb
    begin
        q_next = DIV_N'(prod_reg >> RECIP_SH);
        qw     = DIV_N'(q_next * DIV_N'(WORD_BITS));
    end

endmodule

`default_nettype wire

[rtl/core/bitmap_block_allocator.sv]
// bitmap_block_allocator: first-fit block allocator over a used/free bitmap
// depends on bba_pkg, bba_ram, bba_div
// one request at a time, busy meanwhile
// allocate time is set by the summary scan, format time by the one-word-per-cycle map sweep
// after reset a clearing pass over every map word runs with busy high
// results are a one-cycle done strobe; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 65536,
    parameter int WORD_BITS  = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        start,
    input  wire bba_req_t    req,
    output logic             busy,
    output logic             done,
    output bba_rsp_t         rsp
);

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int SUM_WORDS = (MAP_WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SADDR_W   = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int WB_W      = $clog2(WORD_BITS);
    localparam int POS_RAW   = $clog2(MAP_WORDS * WORD_BITS + WORD_BITS * WORD_BITS) + 1;
    localparam int POS_W     = (POS_RAW > CNT_W + 1) ? POS_RAW : CNT_W + 1;
    localparam int CAP_I     = (MAX_BLOCKS < 65536) ? MAX_BLOCKS : 65536;

    localparam logic [CNT_W-1:0]     LIM_CAP = CNT_W'(CAP_I);
    localparam logic [WADDR_W-1:0]   LAST_W  = WADDR_W'(MAP_WORDS - 1);
    localparam logic [SADDR_W-1:0]   LAST_S  = SADDR_W'(SUM_WORDS - 1);
    localparam logic [WB_W-1:0]      LAST_J  = WB_W'(WORD_BITS - 1);
    localparam logic [POS_W-1:0]     STEP_W  = POS_W'(WORD_BITS);
    localparam logic [POS_W-1:0]     STEP_S  = POS_W'(WORD_BITS * WORD_BITS);
    localparam logic [WORD_BITS-1:0] ONES    = '1;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_AREAD  = 4'd3;
    localparam logic [3:0] S_ACHK   = 4'd4;
    localparam logic [3:0] S_AWORD  = 4'd5;
    localparam logic [3:0] S_ABIT   = 4'd6;
    localparam logic [3:0] S_DIV1   = 4'd7;
    localparam logic [3:0] S_DIV2   = 4'd8;
    localparam logic [3:0] S_TREAD  = 4'd9;
    localparam logic [3:0] S_TBIT   = 4'd10;
    localparam logic [3:0] S_FREAD  = 4'd11;
    localparam logic [3:0] S_FWRITE = 4'd12;

    // control state
    logic [3:0]           state_reg, state_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]     rsv_reg, rsv_next;
    logic [CNT_W-1:0]     free_reg, free_next;
    logic [WADDR_W-1:0]   w_reg, w_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [WORD_BITS-1:0] sacc_reg, sacc_next;
    logic [WB_W-1:0]      sj_reg, sj_next;
    logic [SADDR_W-1:0]   saddr_reg, saddr_next;
    logic [CNT_W-1:0]     r_reg, r_next;
    logic                 fmt_reg, fmt_next;

    // request payload and search scratch
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     lim_reg, lim_next;
    logic [POS_W-1:0]     spos_reg, spos_next;
    logic [POS_W-1:0]     wbase_reg, wbase_next;
    logic [POS_W-1:0]     wpos_reg, wpos_next;
    logic [WB_W-1:0]      j_reg, j_next;
    logic [WB_W-1:0]      b_reg, b_next;
    bba_rsp_t             rsp_reg, rsp_next;

    logic                 map_we;
    logic [WORD_BITS-1:0] map_wdata;
    logic [WORD_BITS-1:0] map_rdata;
    logic                 sum_we;
    logic [WORD_BITS-1:0] sum_wdata;
    logic [WORD_BITS-1:0] sum_rdata;

    logic                 div_go;
    logic [DIV_N-1:0]     div_value;
    logic                 div_vld;
    logic [DIV_N-1:0]     div_quo;
    logic [WB_W-1:0]      div_rem;

    logic [CNT_W-1:0]     lim_in;
    logic [POS_W-1:0]     r_pos;
    logic [POS_W-1:0]     lim_pos;
    logic                 sw_full;
    logic                 sw_empty;
    logic [WB_W-1:0]      sw_k;
    logic [WORD_BITS-1:0] sbits;
    logic [FZ_W-1:0]      fz_sum;
    logic [FZ_W-1:0]      fz_map;
    logic [POS_W-1:0]     spos_inc;
    logic [POS_W-1:0]     alloc_n;
    logic [WORD_BITS-1:0] oh_b;
    logic [WORD_BITS-1:0] oh_j;
    logic [WORD_BITS-1:0] set_word;
    logic                 cfg_wr;

    bba_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (WADDR_W)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (w_reg),
        .wdata (map_wdata),
        .raddr (w_reg),
        .rdata (map_rdata)
    );

    // one bit per map word, set when the word is full
    bba_ram #(
        .DEPTH (SUM_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (SADDR_W)
    ) u_sum (
        .clk   (clk),
        .we    (sum_we),
        .waddr (saddr_reg),
        .wdata (sum_wdata),
        .raddr (saddr_reg),
        .rdata (sum_rdata)
    );

    bba_div #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .value (div_value),
        .vld   (div_vld),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_RSV) ? 32'(rsv_reg) : 32'(total_reg);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    always_comb
    begin
        lim_in    = (total_reg > LIM_CAP) ? LIM_CAP : total_reg;
        r_pos     = POS_W'(r_reg);
        lim_pos   = POS_W'(lim_reg);
        sw_full   = (pos_reg + STEP_W) <= r_pos;
        sw_empty  = pos_reg >= r_pos;
        sw_k      = WB_W'(r_pos - pos_reg);
        fz_sum    = first_zero(~WORD_MAX'(~sum_rdata));
        fz_map    = first_zero(~WORD_MAX'(~map_rdata));
        spos_inc  = spos_reg + STEP_S;
        alloc_n   = wpos_reg + POS_W'(fz_map[WB_W-1:0]);
        oh_b      = WORD_BITS'(1) << b_reg;
        oh_j      = WORD_BITS'(1) << j_reg;
        set_word  = map_rdata | (WORD_BITS'(1) << fz_map[WB_W-1:0]);
        div_value = (state_reg == S_DIV1) ? div_quo : DIV_N'(idx_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        total_next = total_reg;
        rsv_next   = rsv_reg;
        free_next  = free_reg;
        w_next     = w_reg;
        pos_next   = pos_reg;
        sacc_next  = sacc_reg;
        sj_next    = sj_reg;
        saddr_next = saddr_reg;
        r_next     = r_reg;
        fmt_next   = fmt_reg;
        kind_next  = kind_reg;
        idx_next   = idx_reg;
        lim_next   = lim_reg;
        spos_next  = spos_reg;
        wbase_next = wbase_reg;
        wpos_next  = wpos_reg;
        j_next     = j_reg;
        b_next     = b_reg;
        rsp_next   = rsp_reg;
        map_we     = 1'b0;
        map_wdata  = map_rdata;
        sum_we     = 1'b0;
        sum_wdata  = sum_rdata;
        div_go     = 1'b0;
        sbits      = sacc_reg;

        if (cfg_wr)
        begin
            if (paddr[2] == REG_TOTAL)
            begin
                total_next = pwdata[CNT_W-1:0];
            end
            else
            begin
                rsv_next = pwdata[CNT_W-1:0];
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                // one map word per cycle, summary word written once it is assembled
                map_we    = 1'b1;
                map_wdata = sw_full ? ONES : (sw_empty ? '0 : ~(ONES << sw_k));
                sbits[sj_reg] = sw_full;
                if (sj_reg == LAST_J || w_reg == LAST_W)
                begin
                    sum_we     = 1'b1;
                    sum_wdata  = sbits;
                    sacc_next  = ONES;
                    sj_next    = '0;
                    saddr_next = saddr_reg + 1'b1;
                end
                else
                begin
                    sacc_next = sbits;
                    sj_next   = sj_reg + 1'b1;
                end
                w_next   = w_reg + 1'b1;
                pos_next = pos_reg + STEP_W;
                if (w_reg == LAST_W)
                begin
                    if (fmt_reg)
                    begin
                        free_next             = lim_reg - r_reg;
                        rsp_next.status       = ST_OK;
                        rsp_next.block_number = idx_reg;
                        rsp_next.bit_value    = 1'b0;
                        done_next             = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = req.kind;
                    idx_next   = req.block_index;
                    lim_next   = lim_in;
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                rsp_next.block_number = idx_reg;
                rsp_next.bit_value    = 1'b0;
                case (kind_reg)
                    K_ALLOC:
                    begin
                        if (free_reg == '0)
                        begin
                            rsp_next.status = ST_FULL;
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            saddr_next = '0;
                            spos_next  = '0;
                            wbase_next = '0;
                            state_next = S_AREAD;
                        end
                    end
                    K_FREE, K_TEST:
                    begin
                        if ({1'b0, idx_reg} >= lim_reg)
                        begin
                            rsp_next.status = ST_RANGE;
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            div_go     = 1'b1;
                            state_next = S_DIV1;
                        end
                    end
                    default:
                    begin
                        r_next     = (rsv_reg < lim_reg) ? rsv_reg : lim_reg;
                        fmt_next   = 1'b1;
                        w_next     = '0;
                        pos_next   = '0;
                        sacc_next  = ONES;
                        sj_next    = '0;
                        saddr_next = '0;
                        state_next = S_CLEAR;
                    end
                endcase
            end

            S_AREAD:
            begin
                state_next = S_ACHK;
            end

            S_ACHK:
            begin
                if (!fz_sum[FZ_W-1])
                begin
                    j_next     = fz_sum[WB_W-1:0];
                    w_next     = WADDR_W'(wbase_reg + POS_W'(fz_sum[WB_W-1:0]));
                    wpos_next  = spos_reg + POS_W'(fz_sum[WB_W-1:0]) * STEP_W;
                    state_next = S_AWORD;
                end
                else if (saddr_reg == LAST_S || spos_inc >= lim_pos)
                begin
                    rsp_next.status = ST_FULL;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    saddr_next = saddr_reg + 1'b1;
                    spos_next  = spos_inc;
                    wbase_next = wbase_reg + STEP_W;
                    state_next = S_AREAD;
                end
            end

            S_AWORD:
            begin
                // first non-full word starts at or past the usable total
                if (wpos_reg >= lim_pos)
                begin
                    rsp_next.status = ST_FULL;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_ABIT;
                end
            end

            S_ABIT:
            begin
                if (fz_map[FZ_W-1] || alloc_n >= lim_pos)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    map_we                = 1'b1;
                    map_wdata             = set_word;
                    sum_we                = 1'b1;
                    sum_wdata             = sum_rdata
                                          | (WORD_BITS'(set_word == ONES) << j_reg);
                    free_next             = free_reg - 1'b1;
                    rsp_next.status       = ST_OK;
                    rsp_next.block_number = alloc_n[IDX_W-1:0];
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_DIV1:
            begin
                if (div_vld)
                begin
                    w_next = WADDR_W'(div_quo);
                    b_next = div_rem;
                    if (kind_reg == K_TEST)
                    begin
                        state_next = S_TREAD;
                    end
                    else
                    begin
                        div_go     = 1'b1;
                        state_next = S_DIV2;
                    end
                end
            end

            S_DIV2:
            begin
                if (div_vld)
                begin
                    saddr_next = SADDR_W'(div_quo);
                    j_next     = div_rem;
                    state_next = S_FREAD;
                end
            end

            S_TREAD:
            begin
                state_next = S_TBIT;
            end

            S_TBIT:
            begin
                rsp_next.status    = ST_OK;
                rsp_next.bit_value = map_rdata[b_reg];
                done_next          = 1'b1;
                state_next         = S_IDLE;
            end

            S_FREAD:
            begin
                state_next = S_FWRITE;
            end

            S_FWRITE:
            begin
                map_we          = 1'b1;
                map_wdata       = map_rdata & ~oh_b;
                sum_we          = 1'b1;
                sum_wdata       = sum_rdata & ~oh_j;
                if (free_reg != CNT_MAX)
                begin
                    free_next = free_reg + 1'b1;
                end
                rsp_next.status = ST_OK;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
        begin
            rsp_next.free_count = free_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
            total_reg <= TOTAL_RST;
            rsv_reg   <= '0;
            free_reg  <= '0;
            w_reg     <= '0;
            pos_reg   <= '0;
            sacc_reg  <= ONES;
            sj_reg    <= '0;
            saddr_reg <= '0;
            r_reg     <= '0;
            fmt_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            total_reg <= total_next;
            rsv_reg   <= rsv_next;
            free_reg  <= free_next;
            w_reg     <= w_next;
            pos_reg   <= pos_next;
            sacc_reg  <= sacc_next;
            sj_reg    <= sj_next;
            saddr_reg <= saddr_next;
            r_reg     <= r_next;
            fmt_reg   <= fmt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        idx_reg   <= idx_next;
        lim_reg   <= lim_next;
        spos_reg  <= spos_next;
        wbase_reg <= wbase_next;
        wpos_reg  <= wpos_next;
        j_reg     <= j_next;
        b_reg     <= b_next;
        rsp_reg   <= rsp_next;
    end

endmodule

`default_nettype wire
